>>> rtl/core/lsuc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lsuc_pkg
// Shared types and constants of the lens shading uniformity check.
// -----------------------------------------------------------------------------
package lsuc_pkg;

    localparam int CH_W  = 8;
    localparam int LIM_W = 23;
    localparam int IDX_W = 6;

    localparam logic [LIM_W-1:0] RATIO_SAT = 23'd6528000;
    localparam logic [14:0]      UNIT_100  = 15'd25600;
    localparam logic [LIM_W-1:0] MIN_START = 23'd65280;

    // configuration register indexes
    localparam logic [2:0] CFG_Y_LOW    = 3'd0;
    localparam logic [2:0] CFG_Y_HIGH   = 3'd1;
    localparam logic [2:0] CFG_Y_SPREAD = 3'd2;
    localparam logic [2:0] CFG_RG_DIFF  = 3'd3;
    localparam logic [2:0] CFG_BG_DIFF  = 3'd4;

    typedef struct packed {
        logic cap;
        logic div_start;
        logic store;
        logic rd_rst;
        logic rd_inc;
        logic chk_eval;
        logic all_set;
        logic out_load;
        logic frame_clr;
    } lsuc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic frame_end;
        logic rd_is_last;
        logic out_taken;
    } lsuc_sts_t;

endpackage

>>> rtl/core/lsuc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lsuc_div
// Serial restoring divider: floor(num * 25600 / den), one quotient bit a cycle.
// -----------------------------------------------------------------------------
module lsuc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [lsuc_pkg::CH_W-1:0] num,
    input  wire logic [lsuc_pkg::CH_W-1:0] den,
    output logic                           busy,
    output logic [lsuc_pkg::LIM_W-1:0]     quot
);
    import lsuc_pkg::*;

    logic             busy_reg;
    logic [4:0]       cnt_reg;
    logic [LIM_W-1:0] acc_reg;
    logic [CH_W-1:0]  rem_reg;
    logic [CH_W-1:0]  den_reg;
    logic [CH_W:0]    trial;
    logic             ge;
    logic [CH_W:0]    diff;

    assign trial = {rem_reg, acc_reg[LIM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            cnt_reg <= 5'(LIM_W);
            if (den == '0) begin
                acc_reg  <= RATIO_SAT;
                busy_reg <= 1'b0;
            end else begin
                acc_reg  <= LIM_W'(num) * LIM_W'(UNIT_100);
                busy_reg <= 1'b1;
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[CH_W-1:0] : trial[CH_W-1:0];
            acc_reg <= {acc_reg[LIM_W-2:0], ge};
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = acc_reg;

endmodule
`default_nettype wire

>>> rtl/core/lsuc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lsuc_datapath
// Ratio lanes, result store, spread tracking, checks and output word.
// -----------------------------------------------------------------------------
module lsuc_datapath #(
    parameter int MAX_REGIONS = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lsuc_pkg::lsuc_cmd_t       cmd,
    output lsuc_pkg::lsuc_sts_t            sts,
    input  wire logic                      cfg_wr_en,
    input  wire logic [2:0]                cfg_addr,
    input  wire logic [lsuc_pkg::LIM_W-1:0] cfg_wdata,
    input  wire logic [lsuc_pkg::CH_W-1:0] s_ave_y,
    input  wire logic [lsuc_pkg::CH_W-1:0] s_ave_r,
    input  wire logic [lsuc_pkg::CH_W-1:0] s_ave_g,
    input  wire logic [lsuc_pkg::CH_W-1:0] s_ave_b,
    input  wire logic                      s_last_roi,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [lsuc_pkg::IDX_W-1:0]     m_roi_index,
    output logic [lsuc_pkg::LIM_W-1:0]     m_y_ratio,
    output logic [lsuc_pkg::LIM_W-1:0]     m_rg_diff,
    output logic [lsuc_pkg::LIM_W-1:0]     m_bg_diff,
    output logic [lsuc_pkg::LIM_W-1:0]     m_y_spread,
    output logic                           m_y_ok,
    output logic                           m_rg_ok,
    output logic                           m_bg_ok,
    output logic                           m_roi_ok,
    output logic                           m_all_pass,
    output logic                           m_divide_fault,
    output logic                           m_last
);
    import lsuc_pkg::*;

    localparam int AW = (MAX_REGIONS > 2) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = AW + 1;
    localparam int MW = 3 * LIM_W;

    // limits
    logic [LIM_W-1:0] y_low_reg, y_high_reg, spread_lim_reg, rg_lim_reg, bg_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_low_reg      <= '0;
            y_high_reg     <= RATIO_SAT;
            spread_lim_reg <= RATIO_SAT;
            rg_lim_reg     <= RATIO_SAT;
            bg_lim_reg     <= RATIO_SAT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_Y_LOW:    y_low_reg      <= cfg_wdata;
                CFG_Y_HIGH:   y_high_reg     <= cfg_wdata;
                CFG_Y_SPREAD: spread_lim_reg <= cfg_wdata;
                CFG_RG_DIFF:  rg_lim_reg     <= cfg_wdata;
                CFG_BG_DIFF:  bg_lim_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured word and reference
    logic [CH_W-1:0] y_reg, r_reg, g_reg, b_reg;
    logic            last_in_reg;
    logic [CH_W-1:0] ry_reg, rr_reg, rg_reg, rb_reg;
    logic [CW-1:0]   count_reg;
    logic            is_ref;
    logic            fault;

    assign is_ref = (count_reg == '0);
    assign fault  = (ry_reg == '0) || (rr_reg == '0) || (rg_reg == '0) || (rb_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            y_reg       <= s_ave_y;
            r_reg       <= s_ave_r;
            g_reg       <= s_ave_g;
            b_reg       <= s_ave_b;
            last_in_reg <= s_last_roi;
            if (is_ref) begin
                ry_reg <= s_ave_y;
                rr_reg <= s_ave_r;
                rg_reg <= s_ave_g;
                rb_reg <= s_ave_b;
            end
        end
    end

    // four ratio lanes; the reference word uses lanes 1 and 3 for R/G and B/G
    logic [3:0]       busy;
    logic [LIM_W-1:0] q0, q1, q2, q3;

    lsuc_div u_div_y (.aclk, .aresetn, .start(cmd.div_start), .num(y_reg), .den(ry_reg),
                      .busy(busy[0]), .quot(q0));
    lsuc_div u_div_r (.aclk, .aresetn, .start(cmd.div_start), .num(r_reg),
                      .den(is_ref ? g_reg : rr_reg), .busy(busy[1]), .quot(q1));
    lsuc_div u_div_g (.aclk, .aresetn, .start(cmd.div_start), .num(g_reg), .den(rg_reg),
                      .busy(busy[2]), .quot(q2));
    lsuc_div u_div_b (.aclk, .aresetn, .start(cmd.div_start), .num(b_reg),
                      .den(is_ref ? g_reg : rb_reg), .busy(busy[3]), .quot(q3));

    logic [LIM_W-1:0] yr_w, rgd_w, bgd_w;

    assign yr_w  = is_ref ? LIM_W'(UNIT_100) : q0;
    assign rgd_w = is_ref ? q1 : ((q1 > q2) ? (q1 - q2) : (q2 - q1));
    assign bgd_w = is_ref ? q3 : ((q3 > q2) ? (q3 - q2) : (q2 - q3));

    // result store and frame tracking
    logic [MW-1:0]    mem [MAX_REGIONS];
    logic [MW-1:0]    rd_data_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic [LIM_W-1:0] max_reg, min_reg, spread;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[count_reg[AW-1:0]] <= {yr_w, rgd_w, bgd_w};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            max_reg   <= '0;
            min_reg   <= MIN_START;
        end else if (cmd.frame_clr) begin
            count_reg <= '0;
            max_reg   <= '0;
            min_reg   <= MIN_START;
        end else if (cmd.store) begin
            count_reg <= count_reg + 1'b1;
            if (!is_ref) begin
                if (yr_w > max_reg) max_reg <= yr_w;
                if (yr_w < min_reg) min_reg <= yr_w;
            end
        end
    end

    assign spread = (max_reg > min_reg) ? (max_reg - min_reg) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.rd_rst) begin
            rd_addr_reg <= '0;
        end else if (cmd.rd_inc) begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
        end
    end

    // checks on the word read back
    logic [LIM_W-1:0] c_yr, c_rg, c_bg;
    logic             c_ref, c_yok, c_rok, c_bok, c_ok;

    assign {c_yr, c_rg, c_bg} = rd_data_reg;
    assign c_ref = (rd_addr_reg == '0);
    assign c_yok = c_ref || ((c_yr >= y_low_reg) && (c_yr <= y_high_reg));
    assign c_rok = c_ref || (c_rg <= rg_lim_reg);
    assign c_bok = c_ref || (c_bg <= bg_lim_reg);
    assign c_ok  = c_ref || (c_yok && c_rok && c_bok && (spread <= spread_lim_reg));

    logic all_reg;

    always_ff @(posedge aclk) begin
        if (cmd.all_set) begin
            all_reg <= 1'b1;
        end else if (cmd.chk_eval && !c_ok) begin
            all_reg <= 1'b0;
        end
    end

    // output word
    logic valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_roi_index    <= IDX_W'(rd_addr_reg);
            m_y_ratio      <= c_yr;
            m_rg_diff      <= c_rg;
            m_bg_diff      <= c_bg;
            m_y_spread     <= spread;
            m_y_ok         <= c_yok;
            m_rg_ok        <= c_rok;
            m_bg_ok        <= c_bok;
            m_roi_ok       <= c_ok;
            m_all_pass     <= all_reg;
            m_divide_fault <= fault;
            m_last         <= sts.rd_is_last;
        end
    end

    assign m_valid = valid_reg;

    assign sts.div_busy   = |busy;
    assign sts.frame_end  = last_in_reg || (count_reg == CW'(MAX_REGIONS - 1));
    assign sts.rd_is_last = ({1'b0, rd_addr_reg} == (count_reg - 1'b1));
    assign sts.out_taken  = valid_reg && m_ready;

endmodule
`default_nettype wire

>>> rtl/core/lsuc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lsuc_ctrl
// Sequencer: take word, divide, store; at frame end check pass then emit pass.
// -----------------------------------------------------------------------------
module lsuc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lsuc_pkg::lsuc_sts_t sts,
    output lsuc_pkg::lsuc_cmd_t      cmd
);
    import lsuc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_STORE,
        ST_CHK_RD, ST_CHK_EV, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!sts.div_busy) state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (sts.frame_end) begin
                    cmd.rd_rst  = 1'b1;
                    cmd.all_set = 1'b1;
                    state_next  = ST_CHK_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHK_RD: state_next = ST_CHK_EV;
            ST_CHK_EV: begin
                cmd.chk_eval = 1'b1;
                if (sts.rd_is_last) begin
                    cmd.rd_rst = 1'b1;
                    state_next = ST_EM_RD;
                end else begin
                    cmd.rd_inc = 1'b1;
                    state_next = ST_CHK_RD;
                end
            end
            ST_EM_RD: state_next = ST_EM_LD;
            ST_EM_LD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (sts.out_taken) begin
                    if (sts.rd_is_last) begin
                        cmd.frame_clr = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.rd_inc = 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/lens_shading_uniformity_check_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lens_shading_uniformity_check_core
// Per-region Y/R/G/B means in, per-region uniformity verdicts out.
// -----------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  s_      | in        | s_valid/s_ready   | ave_y, ave_r, ave_g, ave_b, last_roi
//  m_      | out       | m_valid/m_ready   | roi_index, ratios, spread, check flags
//  cfg_    | in        | cfg_wr_en         | cfg_addr selects limit, cfg_wdata
//
//  Each input word goes through capture, divider start, 23 bit-serial steps in
//  four parallel ratio dividers, a wait for them to finish, then a store. If
//  every divisor is zero the dividers finish at once. After the last region a
//  check pass (read, then evaluate, per region) folds the frame verdict, then an
//  emit pass reads, loads and holds each result until m_ready takes it.
//  s_ready is high only when idle: low from capture to store, and through the
//  check and emit passes. Reset is synchronous, active low; the result memory
//  is not cleared.
// -----------------------------------------------------------------------------
module lens_shading_uniformity_check_core #(
    parameter int MAX_REGIONS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [2:0]                  cfg_addr,
    input  wire logic [lsuc_pkg::LIM_W-1:0]  cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lsuc_pkg::CH_W-1:0]   s_ave_y,
    input  wire logic [lsuc_pkg::CH_W-1:0]   s_ave_r,
    input  wire logic [lsuc_pkg::CH_W-1:0]   s_ave_g,
    input  wire logic [lsuc_pkg::CH_W-1:0]   s_ave_b,
    input  wire logic                        s_last_roi,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [lsuc_pkg::IDX_W-1:0]       m_roi_index,
    output logic [lsuc_pkg::LIM_W-1:0]       m_y_ratio,
    output logic [lsuc_pkg::LIM_W-1:0]       m_rg_diff,
    output logic [lsuc_pkg::LIM_W-1:0]       m_bg_diff,
    output logic [lsuc_pkg::LIM_W-1:0]       m_y_spread,
    output logic                             m_y_ok,
    output logic                             m_rg_ok,
    output logic                             m_bg_ok,
    output logic                             m_roi_ok,
    output logic                             m_all_pass,
    output logic                             m_divide_fault,
    output logic                             m_last
);
    import lsuc_pkg::*;

    lsuc_cmd_t cmd;
    lsuc_sts_t sts;

    // sequencer: one word at a time, then check and emit passes
    lsuc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .sts, .cmd
    );

    // ratios, result memory, spread and verdict logic
    lsuc_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .s_ave_y, .s_ave_r, .s_ave_g, .s_ave_b, .s_last_roi,
        .m_valid, .m_ready, .m_roi_index, .m_y_ratio, .m_rg_diff, .m_bg_diff,
        .m_y_spread, .m_y_ok, .m_rg_ok, .m_bg_ok, .m_roi_ok, .m_all_pass,
        .m_divide_fault, .m_last
    );

endmodule
`default_nettype wire
